### hw/rtl/apq_pkg.sv
// apq_pkg: shared types and codes for the alarm priority queue.
// Used by the ring buffer, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

    // Command field codes
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // Kind field codes (send only)
    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_ALARM  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_SENT       = 3'd0,
        ST_ALARM_BUSY = 3'd1,
        ST_FIFO_FULL  = 3'd2,
        ST_GOT_ALARM  = 3'd3,
        ST_GOT_NORMAL = 3'd4,
        ST_EMPTY      = 3'd5
    } t_status;

    // Request from the command decode to the ring buffer
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_cmd;

endpackage

`default_nettype wire

### hw/rtl/alarm_priority_queue_top.sv
// alarm_priority_queue_top: command decode, alarm slot and result pipeline.
// Depends on apq_pkg and apq_ring.
`timescale 1ns / 1ps
`default_nettype none

// One command (send or receive) is taken per cycle while o_stall is low and gives
// exactly one result: the decision and all state updates happen in the transfer
// cycle, the ring memory read lands in the next, and the result then passes from
// stage 1 into the output register and sits there until taken. The result path
// holds two entries (one in flight plus the output register) behind the single
// memory read port; while a result is stalled, one more command is still taken.
// Normal messages go to a ring of FIFO_DEPTH entries, the alarm has a slot of its
// own and is always received first. No clearing pass is needed after reset.
module alarm_priority_queue_top
    import apq_pkg::*;
#(
    parameter int FIFO_DEPTH = 16,
    parameter int MSG_WIDTH  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_message_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [2:0]  o_status,
    output logic      [31:0] o_message_out,
    output logic      [4:0]  o_total_count,
    output logic             o_alarm_present
);

    localparam int STORE_W = (MSG_WIDTH < 32) ? MSG_WIDTH : 32;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int TOT_W   = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

    t_ring_cmd          ring_cmd;
    logic [STORE_W-1:0] ring_rd_data;
    logic [CNT_W-1:0]   ring_count;

    logic               accept;
    logic               s1_move;
    logic               n_alarm_valid;
    logic [STORE_W-1:0] n_alarm_handle;
    t_status            n_status;
    logic               n_use_ring;
    logic [STORE_W-1:0] n_msg;
    logic [CNT_W-1:0]   n_count;
    logic [TOT_W-1:0]   n_total;

    logic               r_alarm_valid;
    logic [STORE_W-1:0] r_alarm_handle;

    logic               r_s1_valid;
    t_status            r_s1_status;
    logic               r_s1_use_ring;
    logic [STORE_W-1:0] r_s1_msg;
    logic [4:0]         r_s1_total;
    logic               r_s1_alarm;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [31:0]        r_out_msg;
    logic [4:0]         r_out_total;
    logic               r_out_alarm;

    // Handshake: stage 1 drains into the output register when it is free or taken
    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign accept  = i_valid && !o_stall;

    // Command decode and next state of the alarm slot and ring
    always_comb begin
        ring_cmd       = '0;
        n_alarm_valid  = r_alarm_valid;
        n_alarm_handle = r_alarm_handle;
        n_status       = ST_EMPTY;
        n_use_ring     = 1'b0;
        n_msg          = '0;
        n_count        = ring_count;
        if (i_command == CMD_SEND) begin
            if (i_kind == KIND_ALARM) begin
                if (r_alarm_valid) begin
                    n_status = ST_ALARM_BUSY;
                end else begin
                    n_alarm_valid  = 1'b1;
                    n_alarm_handle = i_message_in[STORE_W-1:0];
                    n_status       = ST_SENT;
                end
            end else if (ring_count == CNT_W'(FIFO_DEPTH)) begin
                n_status = ST_FIFO_FULL;
            end else begin
                ring_cmd.push = accept;
                n_count       = ring_count + 1'b1;
                n_status      = ST_SENT;
            end
        end else begin
            if (r_alarm_valid) begin
                n_msg         = r_alarm_handle;
                n_alarm_valid = 1'b0;
                n_status      = ST_GOT_ALARM;
            end else if (ring_count != '0) begin
                ring_cmd.pop = accept;
                n_use_ring   = 1'b1;
                n_count      = ring_count - 1'b1;
                n_status     = ST_GOT_NORMAL;
            end else begin
                n_status = ST_EMPTY;
            end
        end
        n_total = TOT_W'(n_count) + TOT_W'(n_alarm_valid);
    end

    apq_ring #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .DATA_W     (STORE_W),
        .CNT_W      (CNT_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ring_cmd),
        .i_data    (i_message_in[STORE_W-1:0]),
        .o_rd_data (ring_rd_data),
        .o_count   (ring_count)
    );

    // Alarm slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_valid <= 1'b0;
        end else if (accept) begin
            r_alarm_valid <= n_alarm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_alarm_handle <= n_alarm_handle;
        end
    end

    // Stage 1: waits for the ring read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status   <= n_status;
            r_s1_use_ring <= n_use_ring;
            r_s1_msg      <= n_msg;
            r_s1_total    <= n_total[4:0];
            r_s1_alarm    <= n_alarm_valid;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_msg    <= r_s1_use_ring ? 32'(ring_rd_data) : 32'(r_s1_msg);
            r_out_total  <= r_s1_total;
            r_out_alarm  <= r_s1_alarm;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_message_out   = r_out_msg;
    assign o_total_count   = r_out_total;
    assign o_alarm_present = r_out_alarm;

endmodule

`default_nettype wire

### hw/rtl/apq_ring.sv
// apq_ring: ring buffer of normal messages in a synchronous memory.
// Depends on apq_pkg (t_ring_cmd). Read data is registered and holds until the next pop.
`timescale 1ns / 1ps
`default_nettype none

module apq_ring
    import apq_pkg::*;
#(
    parameter int FIFO_DEPTH = 16,
    parameter int DATA_W     = 32,
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ring_cmd         i_cmd,
    input  wire logic [DATA_W-1:0] i_data,
    output logic      [DATA_W-1:0] o_rd_data,
    output logic      [CNT_W-1:0]  o_count
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

    logic [DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     r_wr_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     n_rd_ptr;
    logic [AW-1:0]     n_wr_ptr;
    logic [CNT_W-1:0]  n_count;

    // Pointer wrap and occupancy; the caller never pushes when full or pops when empty
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_cmd.push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // Memory: one write port, one registered read port.
    // A push and a pop never share a cycle, and a write lands before a later read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

`default_nettype wire

### hw/rtl/apq_checker.sv
// apq_checker: port-level assertions for the alarm priority queue, and its bind.
// Depends on apq_pkg (status codes) and binds to alarm_priority_queue_top.
`timescale 1ns / 1ps
`default_nettype none

module apq_checker
    import apq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_message_out,
    input wire logic [4:0]  o_total_count,
    input wire logic        o_alarm_present
);

    // A stalled result holds until its transfer
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_message_out)
            && $stable(o_total_count) && $stable(o_alarm_present))
        else $error("result changed while stalled");

    // Only a successful receive carries a handle
    a_msg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_SENT || o_status == ST_ALARM_BUSY
            || o_status == ST_FIFO_FULL || o_status == ST_EMPTY) |-> o_message_out == '0)
        else $error("handle on a result without a message");

    // A busy slot is still occupied, a taken alarm leaves it empty
    a_alarm_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ALARM_BUSY || o_status == ST_GOT_ALARM)
            |-> o_alarm_present == (o_status == ST_ALARM_BUSY))
        else $error("alarm flag disagrees with status");

    // Empty means nothing is held at all
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_total_count == '0 && !o_alarm_present)
        else $error("empty result with messages held");

endmodule

bind alarm_priority_queue_top apq_checker u_apq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_message_out   (o_message_out),
    .o_total_count   (o_total_count),
    .o_alarm_present (o_alarm_present)
);

`default_nettype wire
